// ----- rtl/itoa_pkg.sv -----
`timescale 1ns / 1ps

package itoa_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int RADIX_BITS  = 6;
	localparam int DIGIT_BITS  = 6;
	localparam int CHAR_BITS   = 7;
	localparam int STORE_DEPTH = 32;
	localparam int PTR_BITS    = $clog2(STORE_DEPTH);

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
	localparam logic [DIGIT_BITS-1:0] DEC_MAX     = 6'd9;
	localparam logic [DIGIT_BITS-1:0] LETTER_BASE = 6'd10;
	localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_BITS-1:0]  CHAR_A      = 7'd65;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0] radix;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] digit_char;
		logic                 last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_SHOW
	} state_t;

	function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d > DEC_MAX) begin
			c = CHAR_A + {1'b0, d - LETTER_BASE};
		end else begin
			c = CHAR_ZERO + {1'b0, d};
		end
		return c;
	endfunction

	function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
		logic [RADIX_BITS-1:0] c;
		if (r < RADIX_MIN) begin
			c = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			c = RADIX_MAX;
		end else begin
			c = r;
		end
		return c;
	endfunction

endpackage

// ----- rtl/itoa_ram.sv -----
`timescale 1ns / 1ps

module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/itoa_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module itoa_div #(
	parameter int W = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [W-1:0]                     dividend,
	input  logic [itoa_pkg::RADIX_BITS-1:0] divisor,
	output logic                             done,
	output logic [W-1:0]                     quotient,
	output logic [itoa_pkg::DIGIT_BITS-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic [W-1:0]                    quo_q;
	logic [itoa_pkg::DIGIT_BITS-1:0] rem_q;
	logic [itoa_pkg::RADIX_BITS-1:0] div_q;
	logic [CW-1:0]                   cnt_q;
	logic                            run_q;
	logic                            done_q;

	logic [itoa_pkg::DIGIT_BITS:0]   trial;
	logic [itoa_pkg::DIGIT_BITS:0]   diff;
	logic                            ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[itoa_pkg::DIGIT_BITS-1:0] : trial[itoa_pkg::DIGIT_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/integer_to_ascii_radix_core.sv -----
`timescale 1ns / 1ps
// each digit comes from one pass of the bit-serial divider (EW = min(VALUE_WIDTH, 32) bits),
// then each digit is read back from the digit store and shown on the output, where it waits on out_ready
// one item at a time: a new item is taken only after the last digit of the previous item is shown,
// as in_ready is low for the whole item
// reset: arst_n clears the sequencer and divider control, the digit store is not cleared
module integer_to_ascii_radix_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itoa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output itoa_pkg::out_item_t out_data
);

	// bits of the value that take part in the conversion
	localparam int EW = (VALUE_WIDTH < itoa_pkg::VALUE_BITS) ? VALUE_WIDTH : itoa_pkg::VALUE_BITS;
	localparam logic [itoa_pkg::PTR_BITS-1:0] PTR_LAST = itoa_pkg::PTR_BITS'(itoa_pkg::STORE_DEPTH - 1);

	itoa_pkg::state_t state_q, state_d;

	logic                            in_xfer;
	logic                            out_xfer;

	// divider hookup
	logic                            div_start;
	logic [EW-1:0]                   div_dividend;
	logic                            div_done;
	logic [EW-1:0]                   div_quo;
	logic [itoa_pkg::DIGIT_BITS-1:0] div_rem;

	// digit store hookup
	logic                            ram_we;
	logic                            ram_re;
	logic [itoa_pkg::DIGIT_BITS-1:0] ram_rdata;

	logic [itoa_pkg::RADIX_BITS-1:0] radix_q;
	logic [itoa_pkg::PTR_BITS-1:0]   wr_ptr_q;
	logic [itoa_pkg::PTR_BITS-1:0]   rd_ptr_q;

	// another digit is needed while the quotient is nonzero and the store has room
	logic                            more_digits;

	assign in_xfer     = in_valid && in_ready;
	assign out_xfer    = out_valid && out_ready;
	assign more_digits = (div_quo != '0) && (wr_ptr_q != PTR_LAST);

	// first division starts from the input, later ones from the last quotient
	assign div_dividend = (state_q == itoa_pkg::ST_IDLE) ? in_data.value[EW-1:0] : div_quo;

	itoa_div #(
		.W(EW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   ((state_q == itoa_pkg::ST_IDLE) ? itoa_pkg::clamp_radix(in_data.radix) : radix_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	itoa_ram #(
		.WIDTH(itoa_pkg::DIGIT_BITS),
		.DEPTH(itoa_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (div_rem),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = itoa_pkg::ST_DIV;
				end
			end
			itoa_pkg::ST_DIV: begin
				if (div_done && !more_digits) begin
					state_d = itoa_pkg::ST_READ;
				end
			end
			itoa_pkg::ST_READ: begin
				state_d = itoa_pkg::ST_SHOW;
			end
			itoa_pkg::ST_SHOW: begin
				if (out_xfer) begin
					state_d = (rd_ptr_q == '0) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
			end
			itoa_pkg::ST_DIV: begin
				ram_we    = div_done;
				div_start = div_done && more_digits;
			end
			itoa_pkg::ST_READ: begin
				ram_re = 1'b1;
			end
			itoa_pkg::ST_SHOW: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itoa_pkg::ST_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				wr_ptr_q <= '0;
			end else if (ram_we) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				// most significant digit is the one just written
				if (!more_digits) begin
					rd_ptr_q <= wr_ptr_q;
				end
			end
			if (out_xfer && rd_ptr_q != '0) begin
				rd_ptr_q <= rd_ptr_q - 1'b1;
			end
		end
	end

	// radix held for the later divisions of the item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			radix_q <= itoa_pkg::clamp_radix(in_data.radix);
		end
	end

	// read data register holds between reads, so the shown digit stays put
	assign out_data.digit_char = itoa_pkg::to_ascii(ram_rdata);
	assign out_data.last       = (rd_ptr_q == '0);

	// busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("accepted a new item while converting");

	// divider finishes only while the sequencer waits on it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == itoa_pkg::ST_DIV))
		else $error("divider done outside divide phase");

	// final digit returns the block to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_data.last) |=> in_ready)
		else $error("not idle after last digit");

	// no read of or write to the store while a digit is on display
	a_no_read_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !ram_re && !ram_we)
		else $error("digit store accessed while showing a digit");

endmodule
